// ===== design/i2lp_pkg.sv =====
// Package for the interleaved 2bpp line plotter.
// Holds command codes, sequencer states and fixed store constants; no dependencies.
package i2lp_pkg;

  localparam int unsigned StoreDepth = 16384;
  localparam int unsigned ClearBytes = 8000;

  typedef enum logic [1:0] {
    FUNC_PLOT  = 2'd0,
    FUNC_LINE  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIPE,
    ST_LSETUP,
    ST_DIV,
    ST_PIXEL,
    ST_RD,
    ST_WR,
    ST_CLEAR,
    ST_RBACK,
    ST_RBACK2,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        start;
    logic [33:0] num;
    logic [16:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [33:0] quot;
  } div_rsp_t;

endpackage

// ===== design/i2lp_if.sv =====
// Valid/ready channel interfaces for the line plotter.
// Depends on nothing; the payloads follow the command and result fields.
interface i2lp_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  color;
  logic [15:0] x_start;
  logic [15:0] y_start;
  logic [15:0] x_end;
  logic [15:0] y_end;
  logic [13:0] read_address;
  modport source (output valid, func, color, x_start, y_start, x_end, y_end, read_address,
                  input ready);
  modport sink (input valid, func, color, x_start, y_start, x_end, y_end, read_address,
                output ready);
endinterface

interface i2lp_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] read_data;
  modport source (output valid, status, read_data, input ready);
  modport sink (input valid, status, read_data, output ready);
endinterface

// ===== design/interleaved_2bpp_line_plotter_core.sv =====
// Drawing engine for an interleaved 2bpp frame store: plot, line, clear, read back.
// After reset all 16384 store bytes are wiped before the first command is taken.
// Plot, read and clear each end with one result word; a line ends with one after its
// last pixel. Per visited major-axis coordinate a line runs setup, the bit-serial
// divider (34 quotient bits and a done flag) that computes the exact minor coordinate,
// and the read-modify-write of the byte on the single RAM port; the read is skipped
// when the pixel is off screen. Equal endpoints skip the divider and draw one pixel.
// Depends on i2lp_pkg, i2lp_if, i2lp_ram and i2lp_div.
module interleaved_2bpp_line_plotter_core #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 200,
  parameter int unsigned BANK_STRIDE   = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2lp_cmd_if.sink    cmd,
  i2lp_rsp_if.source  rsp
);
  import i2lp_pkg::*;

  state_e state_q, state_d;

  logic [13:0] cnt_q, cnt_d;
  logic [1:0]  color_q, color_d;
  logic        steep_q, steep_d;
  logic        neg_q, neg_d;
  logic [16:0] mstart_q, mstart_d;     // minor start coordinate
  logic [16:0] jstart_q, jstart_d;     // major start coordinate
  logic [16:0] t_q, t_d, hi_q, hi_d;
  logic [16:0] amin_q, amin_d, amaj_q, amaj_d;
  logic [17:0] px_q, px_d, py_q, py_d;
  logic        status_q, status_d;
  logic [7:0]  rdata_q, rdata_d;
  logic        ovalid_q, ovalid_d;

  logic        we;
  logic [13:0] addr;
  logic [7:0]  wdata, ram_q;

  div_req_t dreq;
  div_rsp_t drsp;

  i2lp_ram #(.Width(8), .Depth(StoreDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(ram_q)
  );

  i2lp_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // Pixel address path; coordinates are signed 18-bit.
  logic        on_screen;
  logic [31:0] pix_addr;
  logic [2:0]  shamt;
  logic [7:0]  pmask, pbits;
  always_comb begin
    on_screen = !px_q[17] && !py_q[17] && (px_q < 18'(SCREEN_WIDTH))
                && (py_q < 18'(SCREEN_HEIGHT));
    pix_addr  = ((32'(py_q[16:1]) * 32'(SCREEN_WIDTH) + 32'(px_q[16:0])) >> 2)
                + (py_q[0] ? 32'(BANK_STRIDE) : 32'd0);
    shamt     = 3'd6 - {px_q[1:0], 1'b0};
    pmask     = 8'd3 << shamt;
    pbits     = {6'd0, color_q} << shamt;
  end

  // Line setup values from the command word.
  logic [16:0] dx, dy, adx, ady;
  assign dx  = {1'b0, cmd.x_end} - {1'b0, cmd.x_start};
  assign dy  = {1'b0, cmd.y_end} - {1'b0, cmd.y_start};
  assign adx = dx[16] ? -dx : dx;
  assign ady = dy[16] ? -dy : dy;

  // Exact floor: |minor|*|t-start|/|major|, negated with rounding toward minus infinity.
  // The sign follows the minor delta alone, since t-start always has the major delta's sign.
  logic [16:0] toff;
  logic [33:0] prod;
  logic [17:0] moff;
  logic        rem_nz;
  assign toff = (t_q >= jstart_q) ? t_q - jstart_q : jstart_q - t_q;
  assign prod = 34'(amin_q) * 34'(toff);
  assign rem_nz = (34'(drsp.quot[16:0]) * 34'(amaj_q)) != prod;
  always_comb begin
    if (neg_q) begin
      moff = -(18'(drsp.quot[16:0]) + (rem_nz ? 18'd1 : 18'd0));
    end else begin
      moff = 18'(drsp.quot[16:0]);
    end
  end

  // Plot path: a command with func plot marks status when off screen.
  logic plot_q, plot_d;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    color_d  = color_q;
    steep_d  = steep_q;
    neg_d    = neg_q;
    mstart_d = mstart_q;
    jstart_d = jstart_q;
    t_d      = t_q;
    hi_d     = hi_q;
    amin_d   = amin_q;
    amaj_d   = amaj_q;
    px_d     = px_q;
    py_d     = py_q;
    status_d = status_q;
    rdata_d  = rdata_q;
    ovalid_d = ovalid_q;
    we       = 1'b0;
    addr     = pix_addr[13:0];
    wdata    = (ram_q & ~pmask) | pbits;
    dreq     = '{start: 1'b0, num: prod, den: amaj_q};
    cmd.ready = 1'b0;
    if (rsp.ready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      ST_WIPE: begin
        we    = 1'b1;
        addr  = cnt_q;
        wdata = '0;
        cnt_d = cnt_q + 14'd1;
        if (cnt_q == 14'(StoreDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.ready = !ovalid_q;
        if (cmd.valid && !ovalid_q) begin
          color_d  = cmd.color;
          status_d = 1'b0;
          rdata_d  = '0;
          px_d     = {2'b00, cmd.x_start};
          py_d     = {2'b00, cmd.y_start};
          cnt_d    = '0;
          unique case (func_e'(cmd.func))
            FUNC_PLOT:  state_d = ST_PIXEL;
            FUNC_LINE:  state_d = ST_LSETUP;
            FUNC_CLEAR: state_d = ST_CLEAR;
            FUNC_READ: begin
              state_d = ST_RBACK;
            end
            default: state_d = ST_IDLE;
          endcase
          steep_d  = ady > adx;
          if (ady > adx) begin
            neg_d    = dx[16];
            amin_d   = adx;
            amaj_d   = ady;
            mstart_d = {1'b0, cmd.x_start};
            jstart_d = {1'b0, cmd.y_start};
            t_d      = dy[16] ? {1'b0, cmd.y_end} : {1'b0, cmd.y_start};
            hi_d     = dy[16] ? {1'b0, cmd.y_start} : {1'b0, cmd.y_end};
          end else begin
            neg_d    = dy[16];
            amin_d   = ady;
            amaj_d   = adx;
            mstart_d = {1'b0, cmd.y_start};
            jstart_d = {1'b0, cmd.x_start};
            t_d      = dx[16] ? {1'b0, cmd.x_end} : {1'b0, cmd.x_start};
            hi_d     = dx[16] ? {1'b0, cmd.x_start} : {1'b0, cmd.x_end};
          end
          rdata_d = {2'b00, cmd.read_address[13:8]};
          cnt_d   = {6'd0, cmd.read_address[7:0]};
          if (func_e'(cmd.func) != FUNC_READ) begin
            rdata_d = '0;
            cnt_d   = '0;
          end
        end
      end
      ST_LSETUP: begin
        // Equal endpoints draw the single start pixel.
        if (amaj_q == '0) begin
          state_d = ST_RD;
        end else begin
          dreq.start = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (drsp.done) begin
          if (steep_q) begin
            px_d = 18'(mstart_q) + moff;
            py_d = {1'b0, t_q};
          end else begin
            px_d = {1'b0, t_q};
            py_d = 18'(mstart_q) + moff;
          end
          state_d = ST_PIXEL;
        end
      end
      ST_PIXEL: begin
        if (on_screen) begin
          state_d = ST_RD;
        end else begin
          state_d = ST_WR;
        end
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        we = on_screen && (cnt_q == '0);
        if (cnt_q != '0) begin
          // A nonzero counter also suppresses the write.
          we = 1'b0;
        end
        state_d = ST_OUT;
        if (!plot_q && amaj_q != '0 && t_q != hi_q) begin
          t_d     = t_q + 17'd1;
          state_d = ST_LSETUP;
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        addr  = cnt_q[13] ? 14'(32'(cnt_q[12:0]) + 32'(BANK_STRIDE)) : cnt_q;
        if (cnt_q[13]) begin
          cnt_d = cnt_q + 14'd1;
          if (cnt_q[12:0] == 13'(ClearBytes - 1)) begin
            state_d = ST_OUT;
          end else begin
            cnt_d = {1'b0, cnt_q[12:0] + 13'd1};
          end
        end else begin
          cnt_d = {1'b1, cnt_q[12:0]};
        end
      end
      ST_RBACK: begin
        addr    = {rdata_q[5:0], cnt_q[7:0]};
        state_d = ST_RBACK2;
      end
      ST_RBACK2: begin
        rdata_d = ram_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        ovalid_d = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    plot_d = plot_q;
    if (state_q == ST_IDLE && cmd.valid && cmd.ready) begin
      plot_d = func_e'(cmd.func) == FUNC_PLOT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_WIPE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      plot_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      plot_q   <= plot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q  <= color_d;
    steep_q  <= steep_d;
    neg_q    <= neg_d;
    mstart_q <= mstart_d;
    jstart_q <= jstart_d;
    t_q      <= t_d;
    hi_q     <= hi_d;
    amin_q   <= amin_d;
    amaj_q   <= amaj_d;
    px_q     <= px_d;
    py_q     <= py_d;
    rdata_q  <= rdata_d;
    status_q <= (state_q == ST_PIXEL && plot_q) ? !on_screen : status_d;
  end

  assign rsp.valid     = ovalid_q;
  assign rsp.status    = status_q;
  assign rsp.read_data = rdata_q;
endmodule

// ===== design/i2lp_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module i2lp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== design/i2lp_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on i2lp_pkg for the request and response structs.
module i2lp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2lp_pkg::div_req_t  req_i,
  output i2lp_pkg::div_rsp_t  rsp_o
);
  import i2lp_pkg::*;

  localparam int unsigned NumW = 34;

  logic [NumW-1:0] quot_q, quot_d;
  logic [16:0]     rem_q, rem_d;
  logic [16:0]     den_q, den_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [17:0]     trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[NumW-1]} - {1'b0, den_q};
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 6'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[17]) begin
        rem_d = trial[16:0];
      end else begin
        rem_d = {rem_q[15:0], quot_q[NumW-1]};
      end
      quot_d = {quot_q[NumW-2:0], ~trial[17]};
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
endmodule

// ===== design/i2lp_checker.sv =====
// Port-level checker for the line plotter, bound to the top level.
// Depends on the top level's port names only.
module i2lp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       status_i,
  input logic [7:0] read_data_i
);
  a_no_accept_with_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("word accepted while result pending");
  a_no_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i) else $error("result right after accept");
  a_status_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i) |-> (read_data_i == 8'd0)) else $error("status with read data");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(read_data_i))
    else $error("result dropped");
endmodule

bind interleaved_2bpp_line_plotter_core i2lp_checker u_i2lp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(cmd.valid), .in_ready_i(cmd.ready),
  .out_valid_i(rsp.valid), .out_ready_i(rsp.ready),
  .status_i(rsp.status), .read_data_i(rsp.read_data)
);
